FILE: src/lrcg_pkg.sv
// shared types, constants and register indexes of the layered rainbow color generator
package lrcg_pkg;

	localparam int TIME_W      = 32;
	localparam int PERIOD_W    = 24;
	localparam int COUNT_W     = 7;
	localparam int LAYER_W     = 6;
	localparam int PHASE_W     = 8;
	localparam int COLOR_W     = 8;
	localparam int MAX_LAYERS  = 64;
	localparam int STEP_W      = 6;
	localparam int QUO_W       = 9;
	localparam int SREM_W      = 6;
	localparam int DIV_LAST    = TIME_W + PHASE_W - 1;
	localparam int SMALL_STEPS = 9;
	localparam int SEG_1       = 85;
	localparam int SEG_2       = 170;
	localparam int COLOR_MAX   = 255;

	localparam int PERIOD_RESET = 2000;
	localparam int COUNT_RESET  = 8;

	typedef enum logic {
		REG_PERIOD = 1'b0,
		REG_LAYERS = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIV,
		FR_PUSH
	} front_state_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [COUNT_W-1:0] count;
		logic [QUO_W-1:0]   step_quo;
		logic [SREM_W-1:0]  step_rem;
	} lrcg_job_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} lrcg_rgb_t;

	function automatic lrcg_rgb_t color_wheel(input logic [PHASE_W-1:0] pos);
		lrcg_rgb_t c;
		logic [PHASE_W-1:0] p;
		logic [PHASE_W-1:0] q;
		logic [PHASE_W-1:0] q3;
		p = ~pos;
		if (p < PHASE_W'(SEG_1)) begin
			q = p;
		end else if (p < PHASE_W'(SEG_2)) begin
			q = p - PHASE_W'(SEG_1);
		end else begin
			q = p - PHASE_W'(SEG_2);
		end
		q3 = PHASE_W'({2'b00, q} + {1'b0, q, 1'b0});
		if (p < PHASE_W'(SEG_1)) begin
			c.red   = COLOR_W'(COLOR_MAX) - q3;
			c.green = '0;
			c.blue  = q3;
		end else if (p < PHASE_W'(SEG_2)) begin
			c.red   = '0;
			c.green = q3;
			c.blue  = COLOR_W'(COLOR_MAX) - q3;
		end else begin
			c.red   = q3;
			c.green = COLOR_W'(COLOR_MAX) - q3;
			c.blue  = '0;
		end
		return c;
	endfunction

endpackage

FILE: src/lrcg_front.sv
// front end: accepts timestamps and computes base phase and layer step by serial division
module lrcg_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [lrcg_pkg::TIME_W-1:0]   time_ms,
	input  logic [lrcg_pkg::PERIOD_W-1:0] period_ms,
	input  logic [lrcg_pkg::COUNT_W-1:0]  layer_count,
	output logic                          job_push,
	input  logic                          job_full,
	output lrcg_pkg::lrcg_job_t           job
);
	import lrcg_pkg::*;

	front_state_t        state_q;
	front_state_t        state_d;
	logic [STEP_W-1:0]   step_q;
	logic [TIME_W-1:0]   time_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [SREM_W-1:0]   srem_q;
	logic [QUO_W-1:0]    squo_q;

	logic                accept;
	logic                div_run;
	logic                big_in;
	logic [PERIOD_W:0]   big_tmp;
	logic                big_ge;
	logic [PERIOD_W-1:0] big_next;
	logic [COUNT_W-1:0]  small_tmp;
	logic                small_ge;
	logic [COUNT_W-1:0]  cnt_clamp;
	logic                drop;

	assign accept    = push && !full;
	assign cnt_clamp = (layer_count > COUNT_W'(MAX_LAYERS)) ? COUNT_W'(MAX_LAYERS) : layer_count;
	assign drop      = (cnt_q == '0);

	// long division, dividend bits of the timestamp then eight zeros for the phase
	always_comb begin
		big_in    = (step_q < STEP_W'(TIME_W)) ? time_q[TIME_W-1] : 1'b0;
		big_tmp   = {rem_q, big_in};
		big_ge    = big_tmp >= {1'b0, period_ms};
		big_next  = big_ge ? PERIOD_W'(big_tmp - {1'b0, period_ms}) : big_tmp[PERIOD_W-1:0];
		small_tmp = {srem_q, (step_q == '0)};
		small_ge  = small_tmp >= cnt_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_IDLE: if (push) state_d = FR_DIV;
			FR_DIV:  if (step_q == STEP_W'(DIV_LAST)) state_d = FR_PUSH;
			FR_PUSH: if (!job_full || drop) state_d = FR_IDLE;
			default: state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		full     = 1'b1;
		div_run  = 1'b0;
		job_push = 1'b0;
		unique case (state_q)
			FR_IDLE: full = 1'b0;
			FR_DIV:  div_run = 1'b1;
			FR_PUSH: job_push = !job_full && !drop;
			default: full = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (div_run) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			time_q  <= time_ms;
			rem_q   <= '0;
			phase_q <= '0;
			cnt_q   <= cnt_clamp;
			srem_q  <= '0;
			squo_q  <= '0;
		end else if (div_run) begin
			time_q <= {time_q[TIME_W-2:0], 1'b0};
			rem_q  <= big_next;
			if (step_q >= STEP_W'(TIME_W)) begin
				phase_q <= {phase_q[PHASE_W-2:0], big_ge};
			end
			if (step_q < STEP_W'(SMALL_STEPS)) begin
				squo_q <= {squo_q[QUO_W-2:0], small_ge};
				srem_q <= small_ge ? SREM_W'(small_tmp - cnt_q) : small_tmp[SREM_W-1:0];
			end
		end
	end

	assign job.phase    = (period_ms == '0) ? '0 : phase_q;
	assign job.count    = cnt_q;
	assign job.step_quo = squo_q;
	assign job.step_rem = srem_q;

endmodule

FILE: src/lrcg_queue.sv
// two-entry job queue between front and back end
module lrcg_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  lrcg_pkg::lrcg_job_t wr_data,
	output logic                q_full,
	input  logic                rd_en,
	output lrcg_pkg::lrcg_job_t rd_data,
	output logic                q_empty
);
	import lrcg_pkg::*;

	lrcg_job_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign q_full  = (fill_q == 2'd2);
	assign q_empty = (fill_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= !wr_ptr_q;
			if (rd_en) rd_ptr_q <= !rd_ptr_q;
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

FILE: src/lrcg_back.sv
// back end: walks the layers of one job and drives the result register
module lrcg_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lrcg_pkg::lrcg_job_t          job,
	input  logic                         job_empty,
	output logic                         job_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic [lrcg_pkg::LAYER_W-1:0] layer_index,
	output logic [lrcg_pkg::COLOR_W-1:0] red,
	output logic [lrcg_pkg::COLOR_W-1:0] green,
	output logic [lrcg_pkg::COLOR_W-1:0] blue,
	output logic                         last_layer
);
	import lrcg_pkg::*;

	logic               busy_q;
	lrcg_job_t          job_q;
	logic [LAYER_W-1:0] layer_q;
	logic [PHASE_W-1:0] off_q;
	logic [SREM_W-1:0]  rem_q;
	logic               out_valid_q;
	logic [LAYER_W-1:0] layer_index_q;
	lrcg_rgb_t          rgb_q;
	logic               last_q;

	logic               slot_free;
	logic               emit;
	logic               is_last;
	logic [COUNT_W-1:0] rem_sum;
	logic               wrap;
	logic [PHASE_W-1:0] pos;
	lrcg_rgb_t          rgb;

	assign slot_free = !out_valid_q || pop;
	assign emit      = busy_q && slot_free;
	assign job_pop   = !busy_q && !job_empty;
	assign is_last   = ({1'b0, layer_q} + 1'b1) == job_q.count;
	assign rem_sum   = COUNT_W'({1'b0, rem_q}) + COUNT_W'(job_q.step_rem);
	assign wrap      = rem_sum >= job_q.count;
	assign pos       = job_q.phase + off_q;
	assign rgb       = color_wheel(pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				busy_q <= 1'b1;
			end else if (emit && is_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q   <= job;
			layer_q <= '0;
			off_q   <= '0;
			rem_q   <= '0;
		end else if (emit) begin
			layer_q <= layer_q + 1'b1;
			if (wrap) begin
				rem_q <= SREM_W'(rem_sum - job_q.count);
				off_q <= off_q + job_q.step_quo[PHASE_W-1:0] + 1'b1;
			end else begin
				rem_q <= rem_sum[SREM_W-1:0];
				off_q <= off_q + job_q.step_quo[PHASE_W-1:0];
			end
		end
		if (emit) begin
			layer_index_q <= layer_q;
			rgb_q         <= rgb;
			last_q        <= is_last;
		end
	end

	assign empty       = !out_valid_q;
	assign layer_index = layer_index_q;
	assign red         = rgb_q.red;
	assign green       = rgb_q.green;
	assign blue        = rgb_q.blue;
	assign last_layer  = last_q;

endmodule

FILE: src/layered_rainbow_color_generator_core.sv
// top level of the layered rainbow color generator: registers, front end, job queue, back end
// Each timestamp pushed in yields layer_count color results (layer 0 first, last one flagged,
// none when layer_count is 0, at most 64). After taking a timestamp the front end keeps full
// high while a one-bit-a-cycle restoring divider takes 32 steps for time_ms mod period_ms
// and 8 more for the phase, while the per-layer hue step 256/count is divided out alongside,
// and while a push state hands the job to the queue, waiting as long as the queue is full
// (a job of count 0 is dropped instead). The back end then delivers one layer result per
// cycle as long as results are popped, and it overlaps with the front end's division of the
// next timestamp through a two-entry job queue. Configuration writes are always accepted and
// should be made only while no results are pending.
module layered_rainbow_color_generator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [lrcg_pkg::TIME_W-1:0]   time_ms,
	output logic                          empty,
	input  logic                          pop,
	output logic [lrcg_pkg::LAYER_W-1:0]  layer_index,
	output logic [lrcg_pkg::COLOR_W-1:0]  red,
	output logic [lrcg_pkg::COLOR_W-1:0]  green,
	output logic [lrcg_pkg::COLOR_W-1:0]  blue,
	output logic                          last_layer,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [lrcg_pkg::PERIOD_W-1:0] cfg_data
);
	import lrcg_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	logic [COUNT_W-1:0]  layers_q;
	lrcg_job_t           job_in;
	lrcg_job_t           job_out;
	logic                job_push;
	logic                job_full;
	logic                job_pop;
	logic                job_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_W'(PERIOD_RESET);
			layers_q <= COUNT_W'(COUNT_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_PERIOD: period_q <= cfg_data;
				REG_LAYERS: layers_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	lrcg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.time_ms     (time_ms),
		.period_ms   (period_q),
		.layer_count (layers_q),
		.job_push    (job_push),
		.job_full    (job_full),
		.job         (job_in)
	);

	lrcg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_in),
		.q_full  (job_full),
		.rd_en   (job_pop),
		.rd_data (job_out),
		.q_empty (job_empty)
	);

	lrcg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (job_out),
		.job_empty   (job_empty),
		.job_pop     (job_pop),
		.empty       (empty),
		.pop         (pop),
		.layer_index (layer_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last_layer  (last_layer)
	);

endmodule
